// ----- rtl/core/bbox_affine_expand_clip_unit_defines.svh -----
// Assertion macros shared by the box mapping unit.
`ifndef BBOX_AFFINE_EXPAND_CLIP_UNIT_DEFINES_SVH
`define BBOX_AFFINE_EXPAND_CLIP_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BAEC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BAEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/baec_pkg.sv -----
package baec_pkg;

    // Field widths.
    localparam int EW  = 18;  // input edge, signed Q2.16
    localparam int SW  = 20;  // axis scale, unsigned Q4.16
    localparam int OFW = 18;  // axis offset, signed Q2.16
    localparam int BW  = 18;  // box widening factor, unsigned Q2.16
    localparam int TW  = 16;  // tag
    localparam int QW  = 17;  // output edge, unsigned Q1.16

    // Internal widths, sized so that no intermediate overflows.
    localparam int PW  = 38;  // edge times scale
    localparam int AW  = 23;  // mapped edge, Q.16
    localparam int CW  = 24;  // center and extent, Q.17
    localparam int HPW = 42;  // extent times widening factor
    localparam int XW  = 28;  // widened edge, Q.17

    localparam int FRAC = 16;

    localparam int IN_DW  = 88;  // 4*18 + 16
    localparam int OUT_DW = 88;  // 4*17 + 16, padded to bytes

    localparam logic signed [XW-1:0] Q17_ONE = XW'(131072);

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 20;

    typedef enum logic [CFG_IW-1:0] {
        CFG_SCALE_X   = 3'd0,
        CFG_SCALE_Y   = 3'd1,
        CFG_OFFSET_X  = 3'd2,
        CFG_OFFSET_Y  = 3'd3,
        CFG_BOX_SCALE = 3'd4
    } t_cfg_idx;

    localparam logic [SW-1:0] SCALE_RST = SW'(65536);
    localparam logic [BW-1:0] BOX_RST   = BW'(65536);

endpackage

// ----- rtl/core/bbox_affine_expand_clip_unit.sv -----
// Throughput: one box per cycle while the output accepts; stages advance independently, so bubbles close up.
// No stage iterates: the product of each edge with its scale sits in stage 1 and each axis's extent product
// in stage 4, so each stage passes a box on as soon as the stage after it loads.
// Reset (i_rst_n, synchronous, active low) clears all stage valid bits and loads
// the registers with scale 1.0, offset 0 and widening factor 1.0.
`include "bbox_affine_expand_clip_unit_defines.svh"

module bbox_affine_expand_clip_unit
    import baec_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    // Configuration write channel.
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_IW-1:0]   i_cfg_index,
    input  logic [CFG_DW-1:0]   i_cfg_data,

    // Input boxes.
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // tdata from bit 0: in_left, in_right, in_top, in_bottom (18 bits each), in_tag (16)
    input  logic [IN_DW-1:0]    s_axis_tdata,

    // Result boxes.
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // tdata from bit 0: out_left, out_right, out_top, out_bottom (17 bits each),
    // out_tag (16), four zero pad bits
    output logic [OUT_DW-1:0]   m_axis_tdata
);

    localparam int NSTG = 6;

    // ------------------------------------------------------------------
    // Configuration registers. The user must write them only while the unit is idle;
    // the block itself does not enforce this, and the pipeline reads them directly.
    // ------------------------------------------------------------------
    logic        [SW-1:0]  r_scale_x, r_scale_y;
    logic signed [OFW-1:0] r_offset_x, r_offset_y;
    logic        [BW-1:0]  r_box_scale;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x   <= SCALE_RST;
            r_scale_y   <= SCALE_RST;
            r_offset_x  <= '0;
            r_offset_y  <= '0;
            r_box_scale <= BOX_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SCALE_X:   r_scale_x   <= i_cfg_data[SW-1:0];
                CFG_SCALE_Y:   r_scale_y   <= i_cfg_data[SW-1:0];
                CFG_OFFSET_X:  r_offset_x  <= i_cfg_data[OFW-1:0];
                CFG_OFFSET_Y:  r_offset_y  <= i_cfg_data[OFW-1:0];
                CFG_BOX_SCALE: r_box_scale <= i_cfg_data[BW-1:0];
                default: ;
            endcase
        end
    end

    // Per-axis views: index 0 is x (left/right), index 1 is y (top/bottom).
    logic        [SW-1:0]  w_scale  [2];
    logic signed [OFW-1:0] w_offset [2];

    assign w_scale[0]  = r_scale_x;
    assign w_scale[1]  = r_scale_y;
    assign w_offset[0] = r_offset_x;
    assign w_offset[1] = r_offset_y;

    // ------------------------------------------------------------------
    // Stage handshake. A stage loads when it is empty or when the stage after
    // it loads too, so a stall at the output loses nothing and bubbles are
    // squeezed out before the input is held off.
    // ------------------------------------------------------------------
    logic [NSTG:1] r_vld;
    logic [NSTG:1] w_rdy;
    logic          w_keep;

    always_comb begin
        w_rdy[NSTG] = !r_vld[NSTG] || m_axis_tready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign s_axis_tready = w_rdy[1];
    assign m_axis_tvalid = r_vld[NSTG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[1]) begin
                r_vld[1] <= s_axis_tvalid;
            end
            for (int k = 2; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            // Boxes that fall outside the unit square or end up empty are
            // dropped here and never reach the output.
            if (w_rdy[NSTG]) begin
                r_vld[NSTG] <= r_vld[NSTG-1] && w_keep;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input unpacking.
    // ------------------------------------------------------------------
    logic signed [EW-1:0] w_in_lo [2];
    logic signed [EW-1:0] w_in_hi [2];

    assign w_in_lo[0] = s_axis_tdata[EW-1:0];
    assign w_in_hi[0] = s_axis_tdata[2*EW-1:EW];
    assign w_in_lo[1] = s_axis_tdata[3*EW-1:2*EW];
    assign w_in_hi[1] = s_axis_tdata[4*EW-1:3*EW];

    // Tag shift line, one tap per stage.
    logic [TW-1:0] r_tag [1:NSTG];

    // Stage 1: edge times axis scale.
    logic signed [PW-1:0] r_s1_lo [2];
    logic signed [PW-1:0] r_s1_hi [2];
    logic signed [PW-1:0] n_s1_lo [2];
    logic signed [PW-1:0] n_s1_hi [2];

    // Stage 2: mapped edges, floor of the product plus the offset.
    logic signed [AW-1:0] r_s2_lo [2];
    logic signed [AW-1:0] r_s2_hi [2];
    logic signed [AW-1:0] n_s2_lo [2];
    logic signed [AW-1:0] n_s2_hi [2];

    // Stage 3: center (sum) and extent (difference), both Q.17.
    logic signed [CW-1:0] r_s3_ctr [2];
    logic signed [CW-1:0] r_s3_ext [2];
    logic signed [CW-1:0] n_s3_ctr [2];
    logic signed [CW-1:0] n_s3_ext [2];

    // Stage 4: extent times widening factor, center carried along.
    logic signed [CW-1:0]  r_s4_ctr [2];
    logic signed [HPW-1:0] r_s4_hp  [2];
    logic signed [HPW-1:0] n_s4_hp  [2];

    // Stage 5: widened edges in Q.17.
    logic signed [XW-1:0] r_s5_lo [2];
    logic signed [XW-1:0] r_s5_hi [2];
    logic signed [XW-1:0] n_s5_lo [2];
    logic signed [XW-1:0] n_s5_hi [2];

    // Stage 6: clamped Q1.16 edges at the output.
    logic [QW-1:0] r_s6_lo [2];
    logic [QW-1:0] r_s6_hi [2];
    logic [QW-1:0] n_s6_lo [2];
    logic [QW-1:0] n_s6_hi [2];

    logic signed [XW-1:0] w_half [2];
    logic signed [XW-1:0] w_ctr  [2];
    logic signed [XW-1:0] w_clo  [2];
    logic signed [XW-1:0] w_chi  [2];
    logic                 w_vis;

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            n_s1_lo[a] = $signed({{(PW-EW){w_in_lo[a][EW-1]}}, w_in_lo[a]})
                       * $signed({{(PW-SW){1'b0}}, w_scale[a]});
            n_s1_hi[a] = $signed({{(PW-EW){w_in_hi[a][EW-1]}}, w_in_hi[a]})
                       * $signed({{(PW-SW){1'b0}}, w_scale[a]});

            // Dropping the low fraction bits of a signed value is a floor.
            n_s2_lo[a] = $signed({r_s1_lo[a][PW-1], r_s1_lo[a][PW-1:FRAC]})
                       + $signed({{(AW-OFW){w_offset[a][OFW-1]}}, w_offset[a]});
            n_s2_hi[a] = $signed({r_s1_hi[a][PW-1], r_s1_hi[a][PW-1:FRAC]})
                       + $signed({{(AW-OFW){w_offset[a][OFW-1]}}, w_offset[a]});

            n_s3_ctr[a] = $signed({r_s2_hi[a][AW-1], r_s2_hi[a]})
                        + $signed({r_s2_lo[a][AW-1], r_s2_lo[a]});
            n_s3_ext[a] = $signed({r_s2_hi[a][AW-1], r_s2_hi[a]})
                        - $signed({r_s2_lo[a][AW-1], r_s2_lo[a]});

            n_s4_hp[a] = $signed({{(HPW-CW){r_s3_ext[a][CW-1]}}, r_s3_ext[a]})
                       * $signed({{(HPW-BW){1'b0}}, r_box_scale});

            w_half[a] = $signed({{(XW-(HPW-FRAC)){r_s4_hp[a][HPW-1]}},
                                 r_s4_hp[a][HPW-1:FRAC]});
            w_ctr[a]  = $signed({{(XW-CW){r_s4_ctr[a][CW-1]}}, r_s4_ctr[a]});
            n_s5_lo[a] = w_ctr[a] - w_half[a];
            n_s5_hi[a] = w_ctr[a] + w_half[a];

            // Clamp to [0, 1.0] in Q.17, then drop the lowest bit for Q1.16.
            if (r_s5_lo[a] < 0) begin
                w_clo[a] = '0;
            end else if (r_s5_lo[a] > Q17_ONE) begin
                w_clo[a] = Q17_ONE;
            end else begin
                w_clo[a] = r_s5_lo[a];
            end
            if (r_s5_hi[a] < 0) begin
                w_chi[a] = '0;
            end else if (r_s5_hi[a] > Q17_ONE) begin
                w_chi[a] = Q17_ONE;
            end else begin
                w_chi[a] = r_s5_hi[a];
            end
            n_s6_lo[a] = w_clo[a][QW:1];
            n_s6_hi[a] = w_chi[a][QW:1];
        end

        // The box must overlap the open unit square and stay non-empty after
        // clamping on both axes.
        w_vis  = (r_s5_hi[0] > 0) && (r_s5_lo[0] < Q17_ONE)
              && (r_s5_hi[1] > 0) && (r_s5_lo[1] < Q17_ONE);
        w_keep = w_vis && (n_s6_hi[0] > n_s6_lo[0]) && (n_s6_hi[1] > n_s6_lo[1]);
    end

    // Payload registers load whenever their stage advances; no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_tag[1] <= s_axis_tdata[4*EW+TW-1:4*EW];
            r_s1_lo  <= n_s1_lo;
            r_s1_hi  <= n_s1_hi;
        end
        if (w_rdy[2]) begin
            r_tag[2] <= r_tag[1];
            r_s2_lo  <= n_s2_lo;
            r_s2_hi  <= n_s2_hi;
        end
        if (w_rdy[3]) begin
            r_tag[3] <= r_tag[2];
            r_s3_ctr <= n_s3_ctr;
            r_s3_ext <= n_s3_ext;
        end
        if (w_rdy[4]) begin
            r_tag[4] <= r_tag[3];
            r_s4_ctr <= r_s3_ctr;
            r_s4_hp  <= n_s4_hp;
        end
        if (w_rdy[5]) begin
            r_tag[5] <= r_tag[4];
            r_s5_lo  <= n_s5_lo;
            r_s5_hi  <= n_s5_hi;
        end
        if (w_rdy[6]) begin
            r_tag[6] <= r_tag[5];
            r_s6_lo  <= n_s6_lo;
            r_s6_hi  <= n_s6_hi;
        end
    end

    assign m_axis_tdata = {{(OUT_DW-4*QW-TW){1'b0}}, r_tag[NSTG],
                           r_s6_hi[1], r_s6_lo[1], r_s6_hi[0], r_s6_lo[0]};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `BAEC_ASSERT_NOW(a_out_nonempty, i_clk, i_rst_n, m_axis_tvalid,
        (r_s6_hi[0] > r_s6_lo[0]) && (r_s6_hi[1] > r_s6_lo[1]),
        "empty box reached the output")

    `BAEC_ASSERT_NOW(a_out_in_range, i_clk, i_rst_n, m_axis_tvalid,
        (r_s6_hi[0] <= QW'(65536)) && (r_s6_hi[1] <= QW'(65536)),
        "output edge beyond 1.0")

    `BAEC_ASSERT_NOW(a_hold_only_when_full, i_clk, i_rst_n, !s_axis_tready,
        (r_vld == '1) && !m_axis_tready,
        "input held off while the pipeline has a free stage")

    `BAEC_ASSERT_NEXT(a_drain, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tready && !r_vld[NSTG-1],
        !m_axis_tvalid,
        "result repeated after its transfer")

endmodule
